// ----- rtl/rlzss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlzss_pkg
// Shared constants and types for the reverse lzss decompressor.
// ----------------------------------------------------------------------------
package rlzss_pkg;

	// byte lane width of both channels
	localparam int BYTE_W = 8;

	// type bits supplied by one flag byte
	localparam logic [3:0] FLAG_COUNT = 4'd8;

	// token field layout and biases
	localparam int LEN_W    = 5;
	localparam int DIST_W   = 13;
	localparam logic [LEN_W-1:0]  MIN_LEN  = 5'd3;
	localparam logic [DIST_W-1:0] MIN_DIST = 13'd3;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- rtl/rlzss_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlzss_in_if
// Valid/ready channel carrying compressed bytes into the decompressor.
// ----------------------------------------------------------------------------
interface rlzss_in_if;
	import rlzss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink   (input valid, in_byte, in_last, output ready);

endinterface

// ----- rtl/rlzss_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlzss_out_if
// Valid/ready channel carrying decoded bytes out of the decompressor.
// ----------------------------------------------------------------------------
interface rlzss_out_if;
	import rlzss_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink   (input valid, out_byte, run_last, output ready);

endinterface

// ----- rtl/reverse_lzss_decompressor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reverse_lzss_decompressor
// Byte-serial decoder for backward lzss streams with an on-chip history ram.
// ----------------------------------------------------------------------------
// Usage:
//   compressed : compressed bytes, highest address first; in_last marks the
//                final byte of the compressed region.
//   decoded    : decoded bytes in the same descending order; run_last marks
//                the final byte produced by one compressed word.
//   A word is moved when valid and ready are both high at a clock edge.
// Timing:
//   flag byte, high byte of a reference : accepted, no output
//   literal  : output register loaded at the accepting edge
//   low byte of a reference : accepted, then one history read per
//             copied byte (3 to 18), each passing through the ram read
//             register. The single history ram port pair (one read, one
//             write per cycle) paces the copy while the output is not stalled.
// Reset:
//   arst_n clears the decoder state, write position and output register.
//   The history ram is not cleared; references to unwritten history return
//   whatever it holds.
// Stall:
//   a stalled output holds its word; the copy pauses with its byte kept in
//   the ram read register, and no compressed word is taken until the output
//   register can accept the next result.
// ----------------------------------------------------------------------------
module reverse_lzss_decompressor #(
	parameter int HISTORY_DEPTH = 8192
) (
	input logic        clk,
	input logic        arst_n,
	rlzss_in_if.sink   compressed,
	rlzss_out_if.source decoded
);
	import rlzss_pkg::*;

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
	localparam logic [AW:0]   DEPTH_X   = (AW+1)'(HISTORY_DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   wpos_q;
	byte_t           flag_bits_q;
	logic [3:0]      flags_left_q;
	logic            await_q;
	byte_t           held_q;
	logic [AW-1:0]   rd_addr_q;
	logic [LEN_W-1:0] remain_q;
	logic            clr_pend_q;
	logic            copy_vld_s1;
	logic            copy_last_s1;
	logic            out_valid_q;
	byte_t           out_byte_q;
	logic            run_last_q;

	logic            cmp_acc;
	logic            out_free;
	logic            copy_move;
	logic            copy_issue;
	logic            is_token;
	logic            is_flag;
	logic            is_high;
	logic            lit_emit;
	logic            ram_we;
	byte_t           ram_wdata;
	byte_t           ram_rdata;
	logic            wpos_clr;
	logic [LEN_W-1:0]  tok_len;
	logic [DIST_W-1:0] tok_dist;
	logic [AW:0]     src_diff;
	logic [AW:0]     src_wrap;
	logic [AW-1:0]   src_addr;

	function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
		next_addr = (a == LAST_ADDR) ? '0 : a + 1'b1;
	endfunction

	// handshake and word classification
	assign out_free  = !out_valid_q || decoded.ready;
	assign copy_move = copy_vld_s1 && out_free;
	assign compressed.ready = (state_q == ST_IDLE) && !copy_vld_s1 && out_free;
	assign cmp_acc   = compressed.valid && compressed.ready;
	assign is_token  = await_q;
	assign is_flag   = !await_q && (flags_left_q == '0);
	assign is_high   = !await_q && (flags_left_q != '0) && flag_bits_q[BYTE_W-1];
	assign lit_emit  = cmp_acc && !is_token && !is_flag && !is_high;
	assign copy_issue = (state_q == ST_COPY) && (!copy_vld_s1 || copy_move);

	// token length, distance and copy source
	assign tok_len  = LEN_W'(held_q[BYTE_W-1:4]) + MIN_LEN;
	assign tok_dist = {held_q[3:0], compressed.in_byte} + MIN_DIST;
	assign src_diff = {1'b0, wpos_q} - (AW+1)'(tok_dist);
	assign src_wrap = src_diff + DEPTH_X;
	assign src_addr = src_diff[AW] ? src_wrap[AW-1:0] : src_diff[AW-1:0];

	// history write: literals and copied bytes as they enter the output register
	assign ram_we    = lit_emit || copy_move;
	assign ram_wdata = copy_move ? ram_rdata : compressed.in_byte;
	assign wpos_clr  = (cmp_acc && compressed.in_last && !is_token)
		|| (copy_move && copy_last_s1 && clr_pend_q);

	rlzss_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wpos_q),
		.wdata (ram_wdata),
		.re    (copy_issue),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// decoder state, copy sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wpos_q       <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			await_q      <= 1'b0;
			held_q       <= '0;
			rd_addr_q    <= '0;
			remain_q     <= '0;
			clr_pend_q   <= 1'b0;
			copy_vld_s1  <= 1'b0;
			copy_last_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			run_last_q   <= 1'b0;
		end else begin
			// write position
			if (wpos_clr) begin
				wpos_q <= '0;
			end else if (ram_we) begin
				wpos_q <= next_addr(wpos_q);
			end

			// output register
			if (lit_emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= compressed.in_byte;
				run_last_q  <= 1'b1;
			end else if (copy_move) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= ram_rdata;
				run_last_q  <= copy_last_s1;
			end else if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end

			// read stage
			if (copy_issue) begin
				copy_vld_s1  <= 1'b1;
				copy_last_s1 <= (remain_q == LEN_W'(1));
			end else if (copy_move) begin
				copy_vld_s1 <= 1'b0;
			end
			if (copy_move && copy_last_s1) begin
				clr_pend_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmp_acc) begin
						priority if (is_token) begin
							await_q      <= 1'b0;
							flag_bits_q  <= {flag_bits_q[BYTE_W-2:0], 1'b0};
							flags_left_q <= flags_left_q - 1'b1;
							rd_addr_q    <= src_addr;
							remain_q     <= tok_len;
							clr_pend_q   <= compressed.in_last;
							state_q      <= ST_COPY;
						end else if (is_flag) begin
							flag_bits_q  <= compressed.in_byte;
							flags_left_q <= FLAG_COUNT;
						end else if (is_high) begin
							held_q  <= compressed.in_byte;
							await_q <= 1'b1;
						end else begin
							flag_bits_q  <= {flag_bits_q[BYTE_W-2:0], 1'b0};
							flags_left_q <= flags_left_q - 1'b1;
						end
						// end of region drops any partial token
						if (compressed.in_last) begin
							flag_bits_q  <= '0;
							flags_left_q <= '0;
							await_q      <= 1'b0;
							held_q       <= '0;
						end
					end
				end
				ST_COPY: begin
					if (copy_issue) begin
						rd_addr_q <= next_addr(rd_addr_q);
						remain_q  <= remain_q - 1'b1;
						if (remain_q == LEN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign decoded.valid    = out_valid_q;
	assign decoded.out_byte = out_byte_q;
	assign decoded.run_last = run_last_q;

	// a byte enters history only when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> out_free)
		else $error("history write while output register blocked");

	// copy read never targets the entry being written this cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(copy_issue && ram_we) |-> (rd_addr_q != wpos_q))
		else $error("history read and write collide");

	// no compressed word is taken while a copied byte is still pending
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_acc |-> (!copy_vld_s1 && state_q == ST_IDLE))
		else $error("input accepted during copy");

	// every emitted byte advances the write position unless the region ends
	a_wpos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !wpos_clr) |=> (wpos_q != $past(wpos_q)))
		else $error("write position did not advance");

endmodule

// ----- rtl/rlzss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlzss_ram
// Simple dual-port ram: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rlzss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port, read data holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
